// ===== sv/mld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mouse-look direction unit package
// Shared constants, command and status types, the arctangent table and the
// output saturation used by the controller and the datapath.
// ----------------------------------------------------------------------------
package mld_pkg;

	// Angles in degrees Q.8.
	localparam int DEG360 = 92160;
	localparam int DEG180 = 46080;
	localparam int DEG90  = 23040;

	// Rotation count and gain-compensated start value in Q.30.
	localparam int CORDIC_N = 16;
	localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

	// Configuration register indexes.
	localparam logic [0:0] REG_SENSITIVITY = 1'b0;
	localparam logic [0:0] REG_PITCH_LIMIT = 1'b1;

	// Operations the controller asks of the datapath.
	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_MULX,
		DP_MULY,
		DP_CLAMP,
		DP_WRAP,
		DP_CINIT_YAW,
		DP_CINIT_PITCH,
		DP_CITER,
		DP_CSTORE_YAW,
		DP_CSTORE_PITCH,
		DP_MULC,
		DP_MULS,
		DP_ROUND,
		DP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [3:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULX,
		ST_MULY,
		ST_CLAMP,
		ST_WRAP,
		ST_CINIT_YAW,
		ST_CITER_YAW,
		ST_CSTORE_YAW,
		ST_CINIT_PITCH,
		ST_CITER_PITCH,
		ST_CSTORE_PITCH,
		ST_MULC,
		ST_MULS,
		ST_ROUND,
		ST_PUBLISH
	} ctrl_state_t;

	// Arctangent of 2^-i in degrees Q.16.
	function automatic logic [21:0] atan_q16(input logic [3:0] i);
		logic [21:0] r;
		case (i)
			4'd0:    r = 22'd2949120;
			4'd1:    r = 22'd1740967;
			4'd2:    r = 22'd919879;
			4'd3:    r = 22'd466945;
			4'd4:    r = 22'd234379;
			4'd5:    r = 22'd117304;
			4'd6:    r = 22'd58666;
			4'd7:    r = 22'd29335;
			4'd8:    r = 22'd14668;
			4'd9:    r = 22'd7334;
			4'd10:   r = 22'd3667;
			4'd11:   r = 22'd1833;
			4'd12:   r = 22'd917;
			4'd13:   r = 22'd458;
			4'd14:   r = 22'd229;
			4'd15:   r = 22'd115;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

	// Limit a rounded component to plus or minus one in Q1.14.
	function automatic logic signed [15:0] sat14(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd16384)
			r = 16'sd16384;
		else if (v < -18'sd16384)
			r = -16'sd16384;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/mld_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mouse-look direction unit controller
// Sequences one event through the step products, the yaw wrap, two runs of
// the rotation unit, the direction products and the output register.
// ----------------------------------------------------------------------------
module mld_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire mld_pkg::dp_status_t status,
	output mld_pkg::dp_cmd_t         cmd
);

	mld_pkg::ctrl_state_t state_q, state_d;
	logic [3:0] cnt_q, cnt_d;

	// State and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mld_pkg::ST_IDLE;
			cnt_q   <= 4'd0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd.op   = mld_pkg::DP_NOP;
		cmd.idx  = cnt_q;
		case (state_q)
			mld_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = mld_pkg::DP_LOAD;
					state_d = mld_pkg::ST_MULX;
				end
			end
			mld_pkg::ST_MULX: begin
				cmd.op  = mld_pkg::DP_MULX;
				state_d = mld_pkg::ST_MULY;
			end
			mld_pkg::ST_MULY: begin
				cmd.op  = mld_pkg::DP_MULY;
				state_d = mld_pkg::ST_CLAMP;
			end
			mld_pkg::ST_CLAMP: begin
				cmd.op  = mld_pkg::DP_CLAMP;
				cnt_d   = 4'd7;
				state_d = mld_pkg::ST_WRAP;
			end
			mld_pkg::ST_WRAP: begin
				cmd.op = mld_pkg::DP_WRAP;
				cnt_d  = cnt_q - 4'd1;
				if (cnt_q == 4'd0)
					state_d = mld_pkg::ST_CINIT_YAW;
			end
			mld_pkg::ST_CINIT_YAW: begin
				cmd.op  = mld_pkg::DP_CINIT_YAW;
				cnt_d   = 4'd0;
				state_d = mld_pkg::ST_CITER_YAW;
			end
			mld_pkg::ST_CITER_YAW: begin
				cmd.op = mld_pkg::DP_CITER;
				cnt_d  = cnt_q + 4'd1;
				if (cnt_q == 4'(mld_pkg::CORDIC_N - 1))
					state_d = mld_pkg::ST_CSTORE_YAW;
			end
			mld_pkg::ST_CSTORE_YAW: begin
				cmd.op  = mld_pkg::DP_CSTORE_YAW;
				state_d = mld_pkg::ST_CINIT_PITCH;
			end
			mld_pkg::ST_CINIT_PITCH: begin
				cmd.op  = mld_pkg::DP_CINIT_PITCH;
				cnt_d   = 4'd0;
				state_d = mld_pkg::ST_CITER_PITCH;
			end
			mld_pkg::ST_CITER_PITCH: begin
				cmd.op = mld_pkg::DP_CITER;
				cnt_d  = cnt_q + 4'd1;
				if (cnt_q == 4'(mld_pkg::CORDIC_N - 1))
					state_d = mld_pkg::ST_CSTORE_PITCH;
			end
			mld_pkg::ST_CSTORE_PITCH: begin
				cmd.op  = mld_pkg::DP_CSTORE_PITCH;
				state_d = mld_pkg::ST_MULC;
			end
			mld_pkg::ST_MULC: begin
				cmd.op  = mld_pkg::DP_MULC;
				state_d = mld_pkg::ST_MULS;
			end
			mld_pkg::ST_MULS: begin
				cmd.op  = mld_pkg::DP_MULS;
				state_d = mld_pkg::ST_ROUND;
			end
			mld_pkg::ST_ROUND: begin
				cmd.op  = mld_pkg::DP_ROUND;
				state_d = mld_pkg::ST_PUBLISH;
			end
			mld_pkg::ST_PUBLISH: begin
				// Hold until the output register can take the new word.
				if (!status.out_busy) begin
					cmd.op  = mld_pkg::DP_PUBLISH;
					state_d = mld_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mld_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/mld_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mouse-look direction unit datapath
// Holds the configuration, the cursor and angle state, one shared 32x32
// multiplier, the iterative yaw wrap, the shared rotation unit and the
// output register.
// ----------------------------------------------------------------------------
module mld_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mld_pkg::dp_cmd_t    cmd,
	output mld_pkg::dp_status_t      status,
	input  wire logic                cfg_write,
	input  wire logic [0:0]          cfg_index,
	input  wire logic [15:0]         cfg_data,
	input  wire logic [31:0]         in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [87:0]              out_data
);

	localparam logic signed [17:0] A360 = 18'(mld_pkg::DEG360);
	localparam logic signed [17:0] A180 = 18'(mld_pkg::DEG180);
	localparam logic signed [17:0] A90  = 18'(mld_pkg::DEG90);
	localparam logic [26:0] WRAP_BIAS   = 27'(mld_pkg::DEG360 * 256);
	localparam logic [14:0] LIM_MAX     = 15'(mld_pkg::DEG90);

	// Configuration and event state.
	logic [15:0]        sens_q;
	logic [14:0]        plim_q;
	logic               first_q;
	logic signed [15:0] prev_x_q, prev_y_q;
	logic [16:0]        yaw_acc_q;
	logic signed [15:0] pitch_acc_q;

	// Working registers.
	logic signed [16:0] dx_q, dy_q;
	logic signed [63:0] prod_q;
	logic signed [26:0] red_q;
	logic signed [31:0] x_q, y_q;
	logic signed [25:0] z_q;
	logic               neg_q;
	logic signed [31:0] sy_q, cyw_q, sp_q, cp_q;
	logic signed [15:0] dirx_q, diry_q, dirz_q;
	logic               out_valid_q;
	logic [87:0]        out_data_q;

	// Input fields and deltas; the first event takes its own position as base.
	logic signed [15:0] cx, cy, base_x, base_y;
	assign cx     = in_data[15:0];
	assign cy     = in_data[31:16];
	assign base_x = first_q ? cx : prev_x_q;
	assign base_y = first_q ? cy : prev_y_q;

	// Shared multiplier with operand selection.
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	always_comb begin
		mul_a = {{15{dx_q[16]}}, dx_q};
		mul_b = $signed({16'b0, sens_q});
		case (cmd.op)
			mld_pkg::DP_MULY: mul_a = {{15{dy_q[16]}}, dy_q};
			mld_pkg::DP_MULC: begin
				mul_a = cyw_q;
				mul_b = cp_q;
			end
			mld_pkg::DP_MULS: begin
				mul_a = sy_q;
				mul_b = cp_q;
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Angle step: round half up from Q.16 to Q.8.
	logic signed [33:0] step_sum;
	logic signed [25:0] step;
	assign step_sum = prod_q[33:0] + 34'sd128;
	assign step     = step_sum[33:8];

	// Pitch update clamped to the effective limit.
	logic [14:0]        lim;
	logic signed [26:0] lim_s, psum, pclamp;
	assign lim   = (plim_q > LIM_MAX) ? LIM_MAX : plim_q;
	assign lim_s = $signed({12'b0, lim});
	assign psum  = {{11{pitch_acc_q[15]}}, pitch_acc_q} + {step[25], step};
	always_comb begin
		if (psum > lim_s)
			pclamp = lim_s;
		else if (psum < -lim_s)
			pclamp = -lim_s;
		else
			pclamp = psum;
	end

	// One digit of the yaw reduction modulo 360 degrees.
	logic [26:0] wrap_mod;
	logic [26:0] red_nx;
	assign wrap_mod = 27'(mld_pkg::DEG360) << cmd.idx[2:0];
	assign red_nx   = (red_q >= $signed(wrap_mod)) ? red_q - wrap_mod : red_q;

	// Fold the angle into plus or minus 90 degrees for the rotation unit.
	logic signed [17:0] a0, a1, a2;
	logic               a_neg;
	always_comb begin
		if (cmd.op == mld_pkg::DP_CINIT_YAW)
			a0 = {1'b0, yaw_acc_q};
		else
			a0 = {{2{pitch_acc_q[15]}}, pitch_acc_q};
		a1 = (a0 > A180) ? a0 - A360 : a0;
		a_neg = 1'b0;
		a2 = a1;
		if (a1 > A90) begin
			a2 = a1 - A180;
			a_neg = 1'b1;
		end else if (a1 < -A90) begin
			a2 = a1 + A180;
			a_neg = 1'b1;
		end
	end

	// One rotation step.
	logic signed [31:0] xs, ys;
	logic signed [25:0] atan_v;
	assign xs     = x_q >>> cmd.idx;
	assign ys     = y_q >>> cmd.idx;
	assign atan_v = $signed({4'b0, mld_pkg::atan_q16(cmd.idx)});

	// Rounding of the direction products and the pitch sine.
	logic signed [63:0] prod_rnd;
	logic signed [32:0] sp_rnd;
	assign prod_rnd = prod_q + (64'sd1 <<< 45);
	assign sp_rnd   = {sp_q[31], sp_q} + 33'sd32768;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q <= 16'd6554;
			plim_q <= 15'd22784;
		end else if (cfg_write) begin
			if (cfg_index == mld_pkg::REG_SENSITIVITY)
				sens_q <= cfg_data;
			else if (cfg_index == mld_pkg::REG_PITCH_LIMIT)
				plim_q <= cfg_data[14:0];
		end
	end

	// Cursor and angle state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= 1'b1;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			yaw_acc_q   <= '0;
			pitch_acc_q <= '0;
		end else begin
			case (cmd.op)
				mld_pkg::DP_LOAD: begin
					first_q  <= 1'b0;
					prev_x_q <= cx;
					prev_y_q <= cy;
				end
				mld_pkg::DP_CLAMP: pitch_acc_q <= pclamp[15:0];
				mld_pkg::DP_WRAP: begin
					if (cmd.idx == 4'd0)
						yaw_acc_q <= red_nx[16:0];
				end
				default: ;
			endcase
		end
	end

	// Working registers of the sequence.
	always_ff @(posedge clk) begin
		case (cmd.op)
			mld_pkg::DP_LOAD: begin
				dx_q <= {cx[15], cx} - {base_x[15], base_x};
				dy_q <= {base_y[15], base_y} - {cy[15], cy};
			end
			mld_pkg::DP_MULX: prod_q <= mul_p;
			mld_pkg::DP_MULY: begin
				prod_q <= mul_p;
				red_q  <= $signed({10'b0, yaw_acc_q}) + {step[25], step};
			end
			mld_pkg::DP_CLAMP: begin
				if (red_q[26])
					red_q <= red_q + WRAP_BIAS;
			end
			mld_pkg::DP_WRAP: red_q <= red_nx;
			mld_pkg::DP_CINIT_YAW, mld_pkg::DP_CINIT_PITCH: begin
				x_q   <= mld_pkg::CORDIC_X0;
				y_q   <= '0;
				z_q   <= {a2, 8'b0};
				neg_q <= a_neg;
			end
			mld_pkg::DP_CITER: begin
				if (!z_q[25]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_v;
				end
			end
			mld_pkg::DP_CSTORE_YAW: begin
				sy_q  <= neg_q ? -y_q : y_q;
				cyw_q <= neg_q ? -x_q : x_q;
			end
			mld_pkg::DP_CSTORE_PITCH: begin
				sp_q <= neg_q ? -y_q : y_q;
				cp_q <= neg_q ? -x_q : x_q;
			end
			mld_pkg::DP_MULC: prod_q <= mul_p;
			mld_pkg::DP_MULS: begin
				prod_q <= mul_p;
				dirx_q <= mld_pkg::sat14(prod_rnd[63:46]);
			end
			mld_pkg::DP_ROUND: begin
				dirz_q <= mld_pkg::sat14(prod_rnd[63:46]);
				diry_q <= mld_pkg::sat14({sp_rnd[32], sp_rnd[32:16]});
			end
			default: ;
		endcase
	end

	// Output register; a new word enters only when the old one is gone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == mld_pkg::DP_PUBLISH)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == mld_pkg::DP_PUBLISH)
			out_data_q <= {7'b0, pitch_acc_q, yaw_acc_q, dirz_q, diry_q, dirx_q};
	end

	assign status.out_busy = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_data_q;

endmodule
`default_nettype wire

// ===== sv/mouse_look_direction_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An event (cursor_x, cursor_y) moves yaw and pitch by the scaled cursor
// deltas and yields one word with the view direction in Q1.14 and the new
// angles in degrees Q.8. The first event after reset only takes the cursor
// position as its base. The next event is taken in the cycle after the
// result word of the last one is published. The time per event is set by the
// rotation unit, which runs its 16 steps twice (yaw, then pitch), the 8-step
// yaw wrap, and the single shared multiplier. A finished word sits in the
// output register, and a stalled output delays the next event only once its
// own result is ready. Configuration writes are taken in every cycle and
// must only be made while the unit is idle.
// ----------------------------------------------------------------------------
// Mouse-look direction unit
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
module mouse_look_direction_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// Cursor events.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // cursor_x[15:0], cursor_y[31:16]
	// Direction results.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [87:0]      m_axis_tdata    // dir_x[15:0], dir_y[31:16],
	                                         // dir_z[47:32], yaw_angle[64:48],
	                                         // pitch_angle[80:65], zero[87:81]
);

	mld_pkg::dp_cmd_t    cmd;
	mld_pkg::dp_status_t status;

	// Register writes are always accepted.
	assign cfg_ready = 1'b1;

	mld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	mld_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
`default_nettype wire
